>>> rtl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// Record pool allocator package
// Shared widths, codes, configuration record and controller state type.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int DEFAULT_RECORD_COUNT = 256;

    localparam int INDEX_W        = 8;
    localparam int ADDR_W         = 32;
    localparam int STATUS_W       = 2;
    localparam int POOL_COUNT_W   = 9;
    localparam int RECORD_BYTES_W = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd2;

    localparam logic [POOL_COUNT_W-1:0]   POOL_COUNT_RST   = 9'd256;
    localparam logic [RECORD_BYTES_W-1:0] RECORD_BYTES_RST = 16'd16;
    localparam logic [ADDR_W-1:0]         POOL_BASE_RST    = 32'd0;

    typedef struct packed {
        logic [POOL_COUNT_W-1:0]   pool_count;
        logic [RECORD_BYTES_W-1:0] record_bytes;
        logic [ADDR_W-1:0]         pool_base;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LINK,
        ST_FINISH
    } ctrl_state_t;

endpackage

>>> rtl/rpa_link_ram.sv
// ----------------------------------------------------------------------------
// Record pool link memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module rpa_link_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rpa_addr_gen.sv
// ----------------------------------------------------------------------------
// Record pool address generator
// Registers index times record size, then adds the pool base.
// ----------------------------------------------------------------------------
module rpa_addr_gen #(
    parameter int XW = 9
) (
    input  logic                               clk,
    input  logic                               load,
    input  logic [XW-1:0]                      index,
    input  logic [rpa_pkg::RECORD_BYTES_W-1:0] record_bytes,
    input  logic [rpa_pkg::ADDR_W-1:0]         pool_base,
    output logic [rpa_pkg::ADDR_W-1:0]         address
);
    import rpa_pkg::*;

    localparam int PW = XW + RECORD_BYTES_W;

    logic [PW-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= PW'(index) * PW'(record_bytes);
        end
    end

    // The product never exceeds 25 bits, so the sum wraps only through the base.
    assign address = pool_base + ADDR_W'(product_reg);

endmodule

>>> rtl/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// Record pool controller
// Clears and rebuilds the link memories, then runs allocate and free
// requests as a read, a write of the record and a write of its list neighbors.
// ----------------------------------------------------------------------------
module rpa_ctrl #(
    parameter int RECORD_COUNT = rpa_pkg::DEFAULT_RECORD_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpa_pkg::cfg_t                cfg,
    input  logic                         rebuild,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [rpa_pkg::INDEX_W-1:0]  free_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rpa_pkg::STATUS_W-1:0] status,
    output logic [rpa_pkg::INDEX_W-1:0]  record_index,
    output logic [rpa_pkg::ADDR_W-1:0]   record_address
);
    import rpa_pkg::*;

    localparam int IW = $clog2(RECORD_COUNT);
    localparam int LW = $clog2(RECORD_COUNT + 1);
    localparam int XW = (LW > INDEX_W) ? LW : INDEX_W;
    localparam int CW = (LW > POOL_COUNT_W) ? LW : POOL_COUNT_W;
    localparam logic [LW-1:0] NIL       = LW'(RECORD_COUNT);
    localparam logic [IW-1:0] LAST_ADDR = IW'(RECORD_COUNT - 1);

    ctrl_state_t   state_reg, state_next;
    logic [IW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [LW-1:0] free_top_reg, free_top_next;
    logic [LW-1:0] used_top_reg, used_top_next;

    logic          req_type_reg;
    logic [XW-1:0] idx_reg;
    logic          idx_ok_reg;

    // Plan for the second writes, worked out while the read data is present.
    logic          w2n_en_reg, w2n_en_next;
    logic [IW-1:0] w2n_addr_reg, w2n_addr_next;
    logic [LW-1:0] w2n_data_reg, w2n_data_next;
    logic          w2p_en_reg, w2p_en_next;
    logic [IW-1:0] w2p_addr_reg, w2p_addr_next;
    logic [LW:0]   w2p_data_reg, w2p_data_next;
    logic          ut_load_reg, ut_load_next;
    logic [LW-1:0] ut_val_reg, ut_val_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [XW-1:0]       res_index_reg, res_index_next;
    logic                res_zero_reg, res_zero_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  record_index_reg;
    logic [ADDR_W-1:0]   record_address_reg;

    logic          nwe, pwe;
    logic [IW-1:0] nwa, pwa, raddr;
    logic [LW-1:0] nwd, nrd;
    logic [LW:0]   pwd, prd;

    logic [XW-1:0] idx_in;
    logic          idx_in_ok;
    logic          accept;
    logic          finish_fire;
    logic [CW-1:0] pool_ext;
    logic [CW-1:0] eff_count;
    logic [CW-1:0] sweep_succ;
    logic [LW-1:0] prev_rd;
    logic          alloc_ok;
    logic          free_ok;
    logic          gen_load;
    logic [XW-1:0] gen_index;
    logic [ADDR_W-1:0] gen_address;

    rpa_link_ram #(
        .DEPTH (RECORD_COUNT),
        .AW    (IW),
        .DW    (LW)
    ) u_next_ram (
        .clk   (clk),
        .we    (nwe),
        .waddr (nwa),
        .wdata (nwd),
        .raddr (raddr),
        .rdata (nrd)
    );

    // Each entry holds the in-use flag above the previous link.
    rpa_link_ram #(
        .DEPTH (RECORD_COUNT),
        .AW    (IW),
        .DW    (LW + 1)
    ) u_prev_ram (
        .clk   (clk),
        .we    (pwe),
        .waddr (pwa),
        .wdata (pwd),
        .raddr (raddr),
        .rdata (prd)
    );

    rpa_addr_gen #(
        .XW (XW)
    ) u_addr_gen (
        .clk          (clk),
        .load         (gen_load),
        .index        (gen_index),
        .record_bytes (cfg.record_bytes),
        .pool_base    (cfg.pool_base),
        .address      (gen_address)
    );

    assign idx_in    = XW'(free_index);
    assign idx_in_ok = idx_in < XW'(RECORD_COUNT);
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign finish_fire = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    assign pool_ext  = CW'(cfg.pool_count);
    assign eff_count = (pool_ext == '0) ? CW'(1) :
                       (pool_ext > CW'(RECORD_COUNT)) ? CW'(RECORD_COUNT) : pool_ext;
    assign sweep_succ = CW'(sweep_cnt_reg) + CW'(1);

    assign prev_rd  = prd[LW-1:0];
    assign alloc_ok = (req_type_reg == REQ_ALLOC) && (free_top_reg != NIL);
    assign free_ok  = (req_type_reg == REQ_FREE) && idx_ok_reg && prd[LW];

    assign gen_load  = (state_reg == ST_LINK);
    assign gen_index = (req_type_reg == REQ_ALLOC) ? XW'(free_top_reg) : idx_reg;

    // Both memories are read at the free top, or at the index of a free request.
    always_comb
    begin
        raddr = '0;
        if (req_type == REQ_ALLOC)
        begin
            if (free_top_reg != NIL)
            begin
                raddr = free_top_reg[IW-1:0];
            end
        end
        else if (idx_in_ok)
        begin
            raddr = idx_in[IW-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        free_top_next   = free_top_reg;
        used_top_next   = used_top_reg;
        w2n_en_next     = w2n_en_reg;
        w2n_addr_next   = w2n_addr_reg;
        w2n_data_next   = w2n_data_reg;
        w2p_en_next     = w2p_en_reg;
        w2p_addr_next   = w2p_addr_reg;
        w2p_data_next   = w2p_data_reg;
        ut_load_next    = ut_load_reg;
        ut_val_next     = ut_val_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_zero_next   = res_zero_reg;
        nwe = 1'b0;
        nwa = '0;
        nwd = '0;
        pwe = 1'b0;
        pwa = '0;
        pwd = '0;

        case (state_reg)
            ST_SWEEP:
            begin
                nwe = 1'b1;
                nwa = sweep_cnt_reg;
                nwd = (sweep_succ < eff_count) ? LW'(sweep_succ) : NIL;
                pwe = 1'b1;
                pwa = sweep_cnt_reg;
                pwd = {1'b0, NIL};
                sweep_cnt_next = sweep_cnt_reg + IW'(1);
                if (sweep_cnt_reg == LAST_ADDR)
                begin
                    sweep_cnt_next = '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LINK;
                end
            end

            ST_LINK:
            begin
                w2n_en_next     = 1'b0;
                w2n_addr_next   = '0;
                w2n_data_next   = '0;
                w2p_en_next     = 1'b0;
                w2p_addr_next   = '0;
                w2p_data_next   = '0;
                ut_load_next    = 1'b0;
                ut_val_next     = '0;
                res_status_next = STATUS_OK;
                res_index_next  = gen_index;
                res_zero_next   = 1'b0;
                if (alloc_ok)
                begin
                    // Pop the free top and make it the head of the allocated list.
                    nwe = 1'b1;
                    nwa = free_top_reg[IW-1:0];
                    nwd = used_top_reg;
                    pwe = 1'b1;
                    pwa = free_top_reg[IW-1:0];
                    pwd = {1'b1, NIL};
                    free_top_next = nrd;
                    w2p_en_next   = (used_top_reg != NIL);
                    w2p_addr_next = used_top_reg[IW-1:0];
                    w2p_data_next = {1'b1, free_top_reg};
                    ut_load_next  = 1'b1;
                    ut_val_next   = free_top_reg;
                end
                else if (free_ok)
                begin
                    // Push onto the free stack now, unlink the neighbors in the finish step.
                    nwe = 1'b1;
                    nwa = idx_reg[IW-1:0];
                    nwd = free_top_reg;
                    pwe = 1'b1;
                    pwa = idx_reg[IW-1:0];
                    pwd = {1'b0, NIL};
                    free_top_next = LW'(idx_reg);
                    w2n_en_next   = (prev_rd != NIL);
                    w2n_addr_next = prev_rd[IW-1:0];
                    w2n_data_next = nrd;
                    ut_load_next  = (prev_rd == NIL);
                    ut_val_next   = nrd;
                    w2p_en_next   = (nrd != NIL);
                    w2p_addr_next = nrd[IW-1:0];
                    w2p_data_next = {1'b1, prev_rd};
                end
                else if (req_type_reg == REQ_ALLOC)
                begin
                    res_status_next = STATUS_EMPTY;
                    res_index_next  = '0;
                    res_zero_next   = 1'b1;
                end
                else
                begin
                    res_status_next = STATUS_NOT_ALLOC;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    nwe = w2n_en_reg;
                    nwa = w2n_addr_reg;
                    nwd = w2n_data_reg;
                    pwe = w2p_en_reg;
                    pwa = w2p_addr_reg;
                    pwd = w2p_data_reg;
                    if (ut_load_reg)
                    begin
                        used_top_next = ut_val_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new pool count throws away every list and rebuilds the free chain.
        if (rebuild)
        begin
            state_next     = ST_SWEEP;
            sweep_cnt_next = '0;
            free_top_next  = '0;
            used_top_next  = NIL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            free_top_reg  <= '0;
            used_top_reg  <= NIL;
            w2n_en_reg    <= 1'b0;
            w2p_en_reg    <= 1'b0;
            ut_load_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            free_top_reg  <= free_top_next;
            used_top_reg  <= used_top_next;
            w2n_en_reg    <= w2n_en_next;
            w2p_en_reg    <= w2p_en_next;
            ut_load_reg   <= ut_load_next;
            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w2n_addr_reg   <= w2n_addr_next;
        w2n_data_reg   <= w2n_data_next;
        w2p_addr_reg   <= w2p_addr_next;
        w2p_data_reg   <= w2p_data_next;
        ut_val_reg     <= ut_val_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_zero_reg   <= res_zero_next;
        if (accept)
        begin
            req_type_reg <= req_type;
            idx_reg      <= idx_in;
            idx_ok_reg   <= idx_in_ok;
        end
        if (finish_fire)
        begin
            status_reg         <= res_status_reg;
            record_index_reg   <= res_index_reg[INDEX_W-1:0];
            record_address_reg <= res_zero_reg ? '0 : gen_address;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign record_index   = record_index_reg;
    assign record_address = record_address_reg;

endmodule

>>> rtl/record_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// Record pool allocator
// Hands out and takes back fixed-size records of a pool, with a free stack
// and a doubly linked list of allocated records kept in link memories.
// ----------------------------------------------------------------------------
// Each request first reads the link memories at the record concerned; the
// single write port of each link memory then updates the record and then
// its list neighbors. A new request is taken only after the last one has
// finished; a waiting result holds the block in its last step until it is
// taken. After reset, and after every write of pool_count, a clearing pass
// over all RECORD_COUNT records rebuilds the free chain; no request is
// taken during it, but configuration writes are.
module record_pool_allocator_unit #(
    parameter int RECORD_COUNT = rpa_pkg::DEFAULT_RECORD_COUNT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [rpa_pkg::INDEX_W-1:0]    free_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rpa_pkg::STATUS_W-1:0]   status,
    output logic [rpa_pkg::INDEX_W-1:0]    record_index,
    output logic [rpa_pkg::ADDR_W-1:0]     record_address,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rpa_pkg::*;

    logic [POOL_COUNT_W-1:0]   pool_count_reg;
    logic [RECORD_BYTES_W-1:0] record_bytes_reg;
    logic [ADDR_W-1:0]         pool_base_reg;
    logic                      cfg_write;
    logic                      rebuild;
    cfg_t                      cfg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign rebuild   = cfg_write && (cfg_index == CFG_POOL_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_count_reg   <= POOL_COUNT_RST;
            record_bytes_reg <= RECORD_BYTES_RST;
            pool_base_reg    <= POOL_BASE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_POOL_COUNT:   pool_count_reg   <= cfg_data[POOL_COUNT_W-1:0];
                CFG_RECORD_BYTES: record_bytes_reg <= cfg_data[RECORD_BYTES_W-1:0];
                CFG_POOL_BASE:    pool_base_reg    <= cfg_data[ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.pool_count   = pool_count_reg;
    assign cfg.record_bytes = record_bytes_reg;
    assign cfg.pool_base    = pool_base_reg;

    rpa_ctrl #(
        .RECORD_COUNT (RECORD_COUNT)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .rebuild        (rebuild),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .free_index     (free_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .record_index   (record_index),
        .record_address (record_address)
    );

endmodule

>>> tb/sv/record_pool_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// Record pool allocator unit test
// Drives allocate and free requests, and register writes between phases, into
// the allocator. Each response is checked field by field against a fixed value
// or a behavioral model of the free stack and allocated list kept in this bench.
// ----------------------------------------------------------------------------
module record_pool_allocator_unit_test;

    import rpa_pkg::*;

    localparam int POOL_SIZE = DEFAULT_RECORD_COUNT;
    localparam logic [8:0] LINK_NIL = 9'(POOL_SIZE);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 950;
    localparam int TAIL_CYCLES = 24;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [ADDR_W-1:0]   address;
    } alloc_resp_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic                   req;
        logic [CFG_IDX_W-1:0]   reg_sel;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        alloc_resp_t            want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_type;
    logic [INDEX_W-1:0]    free_index;
    logic                  out_valid;
    logic                  out_ready;
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    record_index;
    logic [ADDR_W-1:0]     record_address;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Model of the pool.
    logic [8:0]            link_next [POOL_SIZE];
    logic [8:0]            link_prev [POOL_SIZE];
    logic                  slot_busy [POOL_SIZE];
    logic [8:0]            spare_top;
    logic [8:0]            busy_head;
    int                    busy_total;
    logic [POOL_COUNT_W-1:0]   cfg_count;
    logic [RECORD_BYTES_W-1:0] cfg_bytes;
    logic [ADDR_W-1:0]         cfg_base;

    alloc_resp_t           awaited_resps [$];
    stim_row_t             dir_rows [$];
    int                    mismatch_count;
    int                    cycle_count;
    logic                  steady;

    record_pool_allocator_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .free_index     (free_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .record_index   (record_index),
        .record_address (record_address),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void rebuild_pool();
        int n;
        n = (cfg_count == 0) ? 1 : ((cfg_count > POOL_SIZE) ? POOL_SIZE : int'(cfg_count));
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            link_next[i] = (i + 1 < n) ? 9'(i + 1) : LINK_NIL;
            link_prev[i] = LINK_NIL;
            slot_busy[i] = 1'b0;
        end
        spare_top  = 9'd0;
        busy_head  = LINK_NIL;
        busy_total = 0;
    endfunction

    function automatic logic [ADDR_W-1:0] record_addr(input logic [INDEX_W-1:0] ix);
        return cfg_base + {24'd0, ix} * {16'd0, cfg_bytes};
    endfunction

    function automatic alloc_resp_t allocator_step(input logic rq, input logic [INDEX_W-1:0] ix);
        alloc_resp_t r;
        logic [8:0]  top;
        logic [8:0]  p;
        logic [8:0]  n;
        if (rq == REQ_ALLOC)
        begin
            top = spare_top;
            if (top == LINK_NIL)
            begin
                r = '{STATUS_EMPTY, 8'd0, 32'd0};
                return r;
            end
            spare_top = link_next[top];
            link_prev[top] = LINK_NIL;
            link_next[top] = busy_head;
            if (busy_head != LINK_NIL)
                link_prev[busy_head] = top;
            busy_head = top;
            slot_busy[top] = 1'b1;
            busy_total++;
            r = '{STATUS_OK, top[7:0], record_addr(top[7:0])};
            return r;
        end
        r = '{STATUS_NOT_ALLOC, ix, record_addr(ix)};
        if (!slot_busy[ix])
            return r;
        // Unlink from the allocated list; a record with no predecessor is the head.
        p = link_prev[ix];
        n = link_next[ix];
        if (p != LINK_NIL)
            link_next[p] = n;
        else
            busy_head = n;
        if (n != LINK_NIL)
            link_prev[n] = p;
        link_next[ix] = spare_top;
        link_prev[ix] = LINK_NIL;
        spare_top = {1'b0, ix};
        slot_busy[ix] = 1'b0;
        busy_total--;
        r.status = STATUS_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_req(input logic rq, input logic [INDEX_W-1:0] ix, input logic typed,
                           input logic [STATUS_W-1:0] st, input logic [INDEX_W-1:0] rix,
                           input logic [ADDR_W-1:0] addr);
        stim_row_t row;
        row.kind    = ROW_REQ;
        row.req     = rq;
        row.reg_sel = CFG_UNUSED;
        row.data    = {24'd0, ix};
        row.typed   = typed;
        row.want    = '{st, rix, addr};
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind    = ROW_CFG;
        row.req     = REQ_ALLOC;
        row.reg_sel = sel;
        row.data    = data;
        row.typed   = 1'b0;
        row.want    = '0;
        dir_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic rq, input logic [INDEX_W-1:0] ix, input logic typed,
                                input alloc_resp_t want);
        alloc_resp_t predicted;
        while (!steady && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        free_index <= ix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = allocator_step(rq, ix);
        awaited_resps.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaited_resps.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] sel,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (sel)
            CFG_POOL_COUNT:
            begin
                cfg_count = data[POOL_COUNT_W-1:0];
                rebuild_pool();
            end
            CFG_RECORD_BYTES: cfg_bytes = data[RECORD_BYTES_W-1:0];
            CFG_POOL_BASE:    cfg_base = data;
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 18);

    always @(posedge clk)
    begin : check_results
        alloc_resp_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_resps.size() == 0)
            begin
                report_mismatch("response with none awaited, index", {24'd0, record_index}, 0);
            end
            else
            begin
                head = awaited_resps.pop_front();
                if (status !== head.status)
                    report_mismatch("status", {30'd0, status}, {30'd0, head.status});
                if (record_index !== head.index)
                    report_mismatch("record_index", {24'd0, record_index}, {24'd0, head.index});
                if (record_address !== head.address)
                    report_mismatch("record_address", record_address, head.address);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        alloc_resp_t no_want;
        int          sent;
        int          phase_len;
        int          alloc_bias;
        int          roll;
        int          k;
        int          pick;
        logic [31:0] value;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = REQ_ALLOC;
        free_index     = '0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_POOL_COUNT;
        cfg_data       = '0;
        steady         = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        no_want        = '0;
        sent           = 0;
        cfg_count      = POOL_COUNT_RST;
        cfg_bytes      = RECORD_BYTES_RST;
        cfg_base       = POOL_BASE_RST;
        rebuild_pool();

        // Reset values: full pool, 16-byte records at address zero.
        add_req(REQ_FREE,  8'd0,   1'b1, STATUS_NOT_ALLOC, 8'd0,   32'd0);
        add_req(REQ_FREE,  8'd255, 1'b1, STATUS_NOT_ALLOC, 8'd255, 32'd4080);
        add_req(REQ_ALLOC, 8'd0,   1'b1, STATUS_OK,        8'd0,   32'd0);
        add_req(REQ_ALLOC, 8'd0,   1'b1, STATUS_OK,        8'd1,   32'd16);
        add_req(REQ_ALLOC, 8'd0,   1'b1, STATUS_OK,        8'd2,   32'd32);
        add_req(REQ_FREE,  8'd1,   1'b0, STATUS_OK, 8'd0, 32'd0);
        add_req(REQ_FREE,  8'd2,   1'b0, STATUS_OK, 8'd0, 32'd0);
        add_req(REQ_FREE,  8'd1,   1'b1, STATUS_NOT_ALLOC, 8'd1,   32'd16);
        add_req(REQ_ALLOC, 8'd0,   1'b0, STATUS_OK, 8'd0, 32'd0);
        add_req(REQ_FREE,  8'd0,   1'b0, STATUS_OK, 8'd0, 32'd0);
        // A count of zero leaves a single record; largest record, top base.
        add_cfg(CFG_POOL_COUNT,   32'd0);
        add_cfg(CFG_RECORD_BYTES, 32'd65535);
        add_cfg(CFG_POOL_BASE,    32'hFFFF_FFFF);
        add_req(REQ_ALLOC, 8'd0,   1'b1, STATUS_OK,        8'd0,   32'hFFFF_FFFF);
        add_req(REQ_ALLOC, 8'd0,   1'b1, STATUS_EMPTY,     8'd0,   32'd0);
        add_req(REQ_FREE,  8'd255, 1'b0, STATUS_OK, 8'd0, 32'd0);
        add_req(REQ_FREE,  8'd0,   1'b1, STATUS_OK,        8'd0,   32'hFFFF_FFFF);
        add_req(REQ_ALLOC, 8'd0,   1'b0, STATUS_OK, 8'd0, 32'd0);
        // An oversized count is clamped to the full pool and rebuilds it.
        add_cfg(CFG_POOL_COUNT,   32'hFFFF_FFFF);
        add_cfg(CFG_UNUSED,       32'hA5A5_5A5A);
        add_cfg(CFG_RECORD_BYTES, 32'd1);
        add_cfg(CFG_POOL_BASE,    32'd0);
        add_req(REQ_FREE,  8'd0,   1'b1, STATUS_NOT_ALLOC, 8'd0,   32'd0);
        add_req(REQ_ALLOC, 8'd0,   1'b1, STATUS_OK,        8'd0,   32'd0);
        add_req(REQ_ALLOC, 8'd0,   1'b1, STATUS_OK,        8'd1,   32'd1);
        add_cfg(CFG_POOL_COUNT,   32'd2);
        add_req(REQ_ALLOC, 8'd0,   1'b0, STATUS_OK, 8'd0, 32'd0);
        add_req(REQ_ALLOC, 8'd0,   1'b0, STATUS_OK, 8'd0, 32'd0);
        add_req(REQ_ALLOC, 8'd0,   1'b1, STATUS_EMPTY,     8'd0,   32'd0);
        add_req(REQ_FREE,  8'd0,   1'b0, STATUS_OK, 8'd0, 32'd0);
        add_req(REQ_FREE,  8'd1,   1'b0, STATUS_OK, 8'd0, 32'd0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
            begin
                drain_results();
                write_register(dir_rows[r].reg_sel, dir_rows[r].data);
            end
            else
            begin
                send_request(dir_rows[r].req, dir_rows[r].data[7:0], dir_rows[r].typed,
                             dir_rows[r].want);
            end
        end

        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            case ($urandom_range(7))
                0:       value = 32'd0;
                1:       value = 32'd1;
                2:       value = 32'd2;
                3:       value = $urandom_range(16, 3);
                4:       value = $urandom_range(255, 17);
                5:       value = 32'd256;
                6:       value = $urandom_range(511, 257);
                default: value = $urandom;
            endcase
            write_register(CFG_POOL_COUNT, value);
            if ($urandom_range(2) != 0)
            begin
                case ($urandom_range(3))
                    0:       value = 32'd1;
                    1:       value = 32'd65535;
                    2:       value = $urandom_range(65535, 1);
                    default: value = $urandom;
                endcase
                write_register(CFG_RECORD_BYTES, value);
            end
            if ($urandom_range(2) != 0)
            begin
                case ($urandom_range(2))
                    0:       value = 32'd0;
                    1:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                write_register(CFG_POOL_BASE, value);
            end
            if ($urandom_range(5) == 0)
                write_register(CFG_UNUSED, $urandom);

            phase_len = $urandom_range(110, 80);
            case ($urandom_range(2))
                0:       alloc_bias = 35;
                1:       alloc_bias = 50;
                default: alloc_bias = 65;
            endcase
            for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++)
            begin
                steady = (sent >= 350 && sent < 500);
                // Hold the sender until the block has answered everything.
                if (sent == 650)
                    drain_results();
                roll = $urandom_range(99);
                if (roll < alloc_bias)
                begin
                    send_request(REQ_ALLOC, 8'($urandom_range(255)), 1'b0, no_want);
                end
                else if (roll < 94 && busy_total > 0)
                begin
                    k = $urandom_range(busy_total - 1);
                    pick = 0;
                    for (int i = 0; i < POOL_SIZE; i++)
                    begin
                        if (slot_busy[i] && k >= 0)
                        begin
                            if (k == 0)
                                pick = i;
                            k--;
                        end
                    end
                    send_request(REQ_FREE, 8'(pick), 1'b0, no_want);
                end
                else
                begin
                    send_request(REQ_FREE, 8'($urandom_range(255)), 1'b0, no_want);
                end
                sent++;
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_resps.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rpa_pkg.sv
rtl/rpa_link_ram.sv
rtl/rpa_addr_gen.sv
rtl/rpa_ctrl.sv
rtl/record_pool_allocator_unit.sv
tb/sv/record_pool_allocator_unit_test.sv
